// ===== design/qspif_pkg.sv =====
// ----------------------------------------------------------------------------
// qspif_pkg
// types, opcodes and helpers shared by the quad spi flash device model
// ----------------------------------------------------------------------------
`default_nettype none

package qspif_pkg;

    localparam int unsigned PAGE_BYTES = 256;
    localparam int unsigned CFG_REGS   = 6;

    localparam logic [2:0] CFG_PROGRAM = 3'd0;
    localparam logic [2:0] CFG_SECTOR  = 3'd1;
    localparam logic [2:0] CFG_WRSR    = 3'd2;
    localparam logic [2:0] CFG_BULK    = 3'd3;
    localparam logic [2:0] CFG_PDOWN   = 3'd4;
    localparam logic [2:0] CFG_RELEASE = 3'd5;

    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_FAST  = 8'h0B;
    localparam logic [7:0] OP_CLSR  = 8'h30;
    localparam logic [7:0] OP_QPP   = 8'h32;
    localparam logic [7:0] OP_RDCR  = 8'h35;
    localparam logic [7:0] OP_RDID  = 8'h9F;
    localparam logic [7:0] OP_RES   = 8'hAB;
    localparam logic [7:0] OP_DP    = 8'hB9;
    localparam logic [7:0] OP_BE    = 8'hC7;
    localparam logic [7:0] OP_SE    = 8'hD8;
    localparam logic [7:0] OP_QREAD = 8'hEB;

    localparam logic [15:0] DEV_ID      = 16'h0115;
    localparam logic [7:0]  DEV_ESD     = 8'h14;
    localparam logic [7:0]  DUMMY_BYTE  = 8'hA5;
    localparam logic [7:0]  IDLE_BYTE   = 8'hFE;
    localparam logic [7:0]  FAST_BYTE   = 8'hC3;
    localparam logic [7:0]  CONT_MAGIC  = 8'hA0;
    localparam logic [9:0]  WR_GUARD    = 10'h203;
    localparam logic [9:0]  WEL_ONLY    = 10'h002;
    localparam logic [9:0]  BUSY_CLEAR  = 10'h0FC;
    localparam logic [9:0]  CLSR_KEEP   = 10'h09F;
    localparam logic [9:0]  WRSR_KEEP   = 10'h061;
    localparam logic [9:0]  WRSR_TAKE   = 10'h09C;
    localparam logic [7:0]  CR_KEEP     = 8'hFD;
    localparam logic [7:0]  CR_TAKE     = 8'h02;
    localparam logic [23:0] SE_ADDR_MSK = 24'hFFC000;
    localparam logic [9:0]  STATUS_RST  = 10'h01C;
    localparam logic [7:0]  SETUP_RST   = 8'h01;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_INVALID,
        CMD_WRSR,
        CMD_PP,
        CMD_QPP,
        CMD_FAST,
        CMD_RDSR,
        CMD_RDCR,
        CMD_RDID,
        CMD_CLSR,
        CMD_RELEASE,
        CMD_SE,
        CMD_BE,
        CMD_QCMD,
        CMD_QREAD,
        CMD_QIDLE
    } cmd_t;

    typedef struct packed {
        logic [9:0]  status;
        logic [7:0]  setup;
        cmd_t        cmd;
        logic        prev_clk;
        logic [31:0] shin;
        logic [11:0] shout;
        logic [6:0]  bitcnt;
        logic [23:0] addr;
        logic        quad;
        logic [7:0]  cont;
        logic [31:0] busy;
    } dev_state_t;

    typedef logic [CFG_REGS-1:0][31:0] cfg_regs_t;

    typedef enum logic [2:0] {
        SW_NONE,
        SW_FILL,
        SW_SECTOR,
        SW_PROGRAM,
        SW_PBFILL
    } sweep_kind_t;

    typedef struct packed {
        sweep_kind_t kind;
        logic [23:0] base;
    } sweep_req_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } pb_wr_t;

    function automatic logic [3:0] pin_out(input logic quad, input logic [11:0] shout);
        logic [3:0] r;
        if (quad)
        begin
            r = shout[11:8];
        end
        else
        begin
            r = {2'b00, shout[8], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/qspif_ram.sv =====
// ----------------------------------------------------------------------------
// qspif_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qspif_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/qspif_step.sv =====
// ----------------------------------------------------------------------------
// qspif_step
// next-state logic for one pin sample: shifter, decoder and command handling
// ----------------------------------------------------------------------------
`default_nettype none

module qspif_step #(
    parameter int SECTOR_BITS = 16
) (
    input  wire qspif_pkg::dev_state_t st,
    input  wire qspif_pkg::cfg_regs_t  cfg,
    input  wire logic             csn,
    input  wire logic             sck,
    input  wire logic [3:0]       din,
    input  wire logic [7:0]       rd_byte,
    output qspif_pkg::dev_state_t nst,
    output logic      [3:0]       dout,
    output qspif_pkg::sweep_req_t sweep,
    output qspif_pkg::pb_wr_t     pbw
);
    import qspif_pkg::*;

    localparam logic [23:0] SECTOR_MASK = ~((24'd1 << SECTOR_BITS) - 24'd1);

    dev_state_t s;
    logic [6:0] n;
    logic       may_wr;

    always_comb
    begin
        s      = st;
        dout   = '0;
        sweep  = '{kind: SW_NONE, base: '0};
        pbw    = '0;
        n      = '0;
        may_wr = 1'b0;

        if (s.busy != 32'd0)
        begin
            s.busy = s.busy - 32'd1;
            if (s.busy == 32'd0)
            begin
                s.status = s.status & BUSY_CLEAR;
            end
        end

        if (csn)
        begin
            s.prev_clk = 1'b1;
            s.shin     = '0;
            s.bitcnt   = '0;
            case (s.cmd)
                CMD_PP, CMD_QPP:
                begin
                    s.busy     = cfg[CFG_PROGRAM];
                    s.cmd      = CMD_IDLE;
                    s.status   = (s.status & ~WEL_ONLY) | 10'h001;
                    sweep.kind = SW_PROGRAM;
                    sweep.base = {s.addr[23:8], 8'h00};
                    s.quad     = 1'b0;
                end
                CMD_SE:
                begin
                    s.busy     = cfg[CFG_SECTOR];
                    s.cmd      = CMD_IDLE;
                    s.status   = (s.status & ~WEL_ONLY) | 10'h001;
                    s.addr     = s.addr & SECTOR_MASK;
                    sweep.kind = SW_SECTOR;
                    sweep.base = s.addr;
                end
                CMD_WRSR:
                begin
                    s.busy   = cfg[CFG_WRSR];
                    s.cmd    = CMD_IDLE;
                    s.status = (s.status & ~WEL_ONLY) | 10'h001;
                end
                CMD_CLSR:
                begin
                    s.cmd    = CMD_IDLE;
                    s.status = s.status & CLSR_KEEP;
                end
                CMD_BE:
                begin
                    s.busy     = cfg[CFG_BULK];
                    s.cmd      = CMD_IDLE;
                    s.status   = (s.status & ~WEL_ONLY) | 10'h001;
                    sweep.kind = SW_FILL;
                end
                CMD_RELEASE:
                begin
                    s.busy = cfg[CFG_RELEASE];
                    s.cmd  = CMD_IDLE;
                end
                CMD_QCMD, CMD_QREAD:
                begin
                    if (s.cont[7:4] != CONT_MAGIC[7:4])
                    begin
                        s.quad = 1'b0;
                    end
                    else
                    begin
                        s.cmd = CMD_QIDLE;
                    end
                end
                default:
                begin
                end
            endcase
            s.shout = {4'h0, IDLE_BYTE};
            dout    = din;
        end
        else if (!s.prev_clk || (sck == s.prev_clk))
        begin
            s.prev_clk = sck;
            dout       = pin_out(s.quad, s.shout);
        end
        else
        begin
            if (s.quad)
            begin
                s.shin   = {s.shin[27:0], din};
                s.bitcnt = s.bitcnt + 7'd4;
                s.shout  = {s.shout[7:0], 4'h0};
            end
            else
            begin
                s.shin   = {s.shin[30:0], din[0]};
                s.bitcnt = s.bitcnt + 7'd1;
                s.shout  = {s.shout[10:0], 1'b0};
            end
            if (s.bitcnt >= 7'd80)
            begin
                s.bitcnt = s.bitcnt - 7'd16;
            end
            n      = s.bitcnt;
            may_wr = ((s.status & WR_GUARD) == WEL_ONLY);

            if (s.cmd == CMD_QIDLE)
            begin
                if (n == 7'd24)
                begin
                    s.addr = s.shin[23:0];
                    s.cmd  = CMD_QREAD;
                end
                s.shout = '0;
            end
            else if (n == 7'd8)
            begin
                s.shout[7:0] = DUMMY_BYTE;
                case (s.shin[7:0])
                    OP_WRSR:  s.cmd = may_wr ? CMD_WRSR : CMD_INVALID;
                    OP_PP:    s.cmd = may_wr ? CMD_PP : CMD_INVALID;
                    OP_WRDI:
                    begin
                        s.cmd    = CMD_IDLE;
                        s.status = s.status & ~WEL_ONLY;
                    end
                    OP_RDSR:
                    begin
                        s.cmd        = CMD_RDSR;
                        s.shout[7:0] = s.status[7:0];
                    end
                    OP_WREN:
                    begin
                        s.cmd    = CMD_IDLE;
                        s.status = s.status | WEL_ONLY;
                    end
                    OP_FAST:  s.cmd = CMD_FAST;
                    OP_CLSR:  s.cmd = CMD_CLSR;
                    OP_QPP:   s.cmd = may_wr ? CMD_QPP : CMD_INVALID;
                    OP_RDCR:
                    begin
                        s.cmd        = CMD_RDCR;
                        s.shout[7:0] = s.setup;
                    end
                    OP_RDID:
                    begin
                        s.cmd        = CMD_RDID;
                        s.shout[7:0] = IDLE_BYTE;
                    end
                    OP_RES:
                    begin
                        if (s.status[9])
                        begin
                            s.status[9] = 1'b0;
                            s.busy      = cfg[CFG_RELEASE];
                        end
                        s.cmd = CMD_RELEASE;
                    end
                    OP_DP:
                    begin
                        if (s.status[0])
                        begin
                            s.cmd = CMD_INVALID;
                        end
                        else
                        begin
                            s.status[9] = 1'b1;
                            s.cmd       = CMD_IDLE;
                        end
                    end
                    OP_BE:    s.cmd = may_wr ? CMD_BE : CMD_INVALID;
                    OP_SE:    s.cmd = may_wr ? CMD_SE : CMD_INVALID;
                    OP_QREAD:
                    begin
                        s.cmd  = CMD_QCMD;
                        s.quad = 1'b1;
                    end
                    default:  s.cmd = CMD_INVALID;
                endcase
            end
            else if ((n[2:0] == 3'd0) && (n != 7'd0))
            begin
                s.shout[7:0] = 8'h00;
                case (s.cmd)
                    CMD_WRSR:
                    begin
                        if (n == 7'd16)
                        begin
                            s.status = (s.status & WRSR_KEEP) | (s.shin[9:0] & WRSR_TAKE);
                        end
                        else if (n == 7'd24)
                        begin
                            s.setup = (s.setup & CR_KEEP) | (s.shin[7:0] & CR_TAKE);
                        end
                        else
                        begin
                            s.cmd = CMD_IDLE;
                        end
                    end
                    CMD_RDID:
                    begin
                        if (n == 7'd32)
                        begin
                            s.addr       = s.shin[23:0];
                            s.shout[7:0] = DEV_ID[15:8];
                        end
                        else if (n > 7'd32)
                        begin
                            s.shout[7:0] = n[3] ? DEV_ID[7:0] : DEV_ID[15:8];
                        end
                    end
                    CMD_RDSR: s.shout[7:0] = s.status[7:0];
                    CMD_RDCR: s.shout[7:0] = s.setup;
                    CMD_FAST:
                    begin
                        if (n == 7'd32)
                        begin
                            s.addr       = s.shin[23:0];
                            s.shout[7:0] = FAST_BYTE;
                        end
                        else if ((n >= 7'd40) && !s.status[0])
                        begin
                            s.shout[7:0] = rd_byte;
                            s.addr       = s.addr + 24'd1;
                        end
                        else
                        begin
                            s.shout = '0;
                        end
                    end
                    CMD_QCMD:
                    begin
                        if (n == 7'd32)
                        begin
                            s.addr = s.shin[23:0];
                        end
                        else if (n == 7'd56)
                        begin
                            s.cont = s.shin[23:16];
                        end
                        else if ((n > 7'd56) && !s.status[0])
                        begin
                            s.shout[7:0] = rd_byte;
                            s.addr       = s.addr + 24'd1;
                        end
                        else
                        begin
                            s.shout = '0;
                        end
                    end
                    CMD_QREAD:
                    begin
                        if (n == 7'd32)
                        begin
                            s.cont = s.shin[7:0];
                        end
                        else if ((n >= 7'd48) && !s.status[0])
                        begin
                            s.shout[7:0] = rd_byte;
                            s.addr       = s.addr + 24'd1;
                        end
                        else
                        begin
                            s.shout = '0;
                        end
                    end
                    CMD_PP, CMD_QPP:
                    begin
                        if (n == 7'd32)
                        begin
                            s.addr = s.shin[23:0];
                            if (s.cmd == CMD_QPP)
                            begin
                                s.quad = 1'b1;
                            end
                            sweep.kind = SW_PBFILL;
                        end
                        else if (n >= 7'd40)
                        begin
                            pbw.en      = 1'b1;
                            pbw.addr    = s.addr[7:0];
                            pbw.data    = s.shin[7:0];
                            s.addr[7:0] = s.addr[7:0] + 8'd1;
                        end
                    end
                    CMD_SE:
                    begin
                        if (n == 7'd32)
                        begin
                            s.addr = s.shin[23:0] & SE_ADDR_MSK;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (n >= 7'd32)
                        begin
                            s.shout[7:0] = DEV_ESD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            s.prev_clk = sck;
            dout       = pin_out(s.quad, s.shout);
        end
        nst = s;
    end

endmodule

`default_nettype wire

// ===== design/quad_spi_flash_device_model_unit.sv =====
// ----------------------------------------------------------------------------
// quad_spi_flash_device_model_unit
// quad spi nor flash device model driven by one pin sample per request
// ----------------------------------------------------------------------------
// Each request carries one sample of chip select, serial clock and the four
// data lines and yields one data_out sample. For each request the flash byte
// at the current address is read from the flash memory, then the device
// state is updated once the output can take a new data_out sample. After
// reset the whole flash memory is preset to 0xFF, one byte per cycle, before
// the first request is taken. Requests that start a walk over a memory hold
// the input until the walk is done: the page buffer preset to 0xFF, a page
// program of one page, a sector erase and a bulk erase of the whole flash.
// Configuration writes are taken in any cycle.
`default_nettype none

module quad_spi_flash_device_model_unit #(
    parameter int ADDR_BITS   = 22,
    parameter int SECTOR_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // chip_select_n, serial_clock, data_in[3:0], 0
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // data_out[3:0], 0
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import qspif_pkg::*;

    localparam int CW = ((ADDR_BITS > SECTOR_BITS) ? ADDR_BITS : SECTOR_BITS) + 1;
    localparam logic [CW-1:0] LIM_ALL  = CW'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [CW-1:0] LIM_SEC  = CW'((64'd1 << SECTOR_BITS) - 64'd1);
    localparam logic [CW-1:0] LIM_PB   = CW'(PAGE_BYTES - 1);
    localparam logic [CW-1:0] LIM_PROG = CW'(PAGE_BYTES);

    typedef enum logic [1:0] {
        F_CLEAR,
        F_IDLE,
        F_EXEC,
        F_SWEEP
    } fsm_t;

    fsm_t                 fsm_reg;
    dev_state_t           st_reg;
    cfg_regs_t            cfg_reg;
    logic                 csn_reg;
    logic                 sck_reg;
    logic [3:0]           din_reg;
    logic                 out_valid_reg;
    logic [3:0]           out_data_reg;
    sweep_kind_t          sw_kind_reg;
    logic [23:0]          sw_base_reg;
    logic [CW-1:0]        cnt_reg;

    dev_state_t           nst;
    logic [3:0]           dout;
    sweep_req_t           sweep;
    pb_wr_t               pbw;

    logic                 f_we;
    logic [ADDR_BITS-1:0] f_waddr;
    logic [7:0]           f_wdata;
    logic [ADDR_BITS-1:0] f_raddr;
    logic [7:0]           f_rdata;
    logic                 p_we;
    logic [7:0]           p_waddr;
    logic [7:0]           p_wdata;
    logic [7:0]           p_rdata;
    logic [ADDR_BITS-1:0] sw_addr;
    logic [CW-1:0]        limit;
    logic                 load;

    assign s_axis_tready = (fsm_reg == F_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_data_reg};
    assign load          = (fsm_reg == F_EXEC) && (!out_valid_reg || m_axis_tready);
    assign sw_addr       = sw_base_reg[ADDR_BITS-1:0] + cnt_reg[ADDR_BITS-1:0];

    qspif_step #(
        .SECTOR_BITS (SECTOR_BITS)
    ) u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .csn     (csn_reg),
        .sck     (sck_reg),
        .din     (din_reg),
        .rd_byte (f_rdata),
        .nst     (nst),
        .dout    (dout),
        .sweep   (sweep),
        .pbw     (pbw)
    );

    qspif_ram #(
        .AW (ADDR_BITS),
        .DW (8)
    ) u_flash (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    qspif_ram #(
        .AW (8),
        .DW (8)
    ) u_page (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (cnt_reg[7:0]),
        .rdata (p_rdata)
    );

    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = cnt_reg[ADDR_BITS-1:0];
        f_wdata = 8'hFF;
        f_raddr = st_reg.addr[ADDR_BITS-1:0];
        p_we    = load && pbw.en;
        p_waddr = pbw.addr;
        p_wdata = pbw.data;
        limit   = LIM_ALL;
        case (fsm_reg)
            F_CLEAR:
            begin
                f_we = 1'b1;
            end
            F_SWEEP:
            begin
                case (sw_kind_reg)
                    SW_FILL:
                    begin
                        f_we = 1'b1;
                    end
                    SW_SECTOR:
                    begin
                        f_we    = 1'b1;
                        f_waddr = sw_addr;
                        limit   = LIM_SEC;
                    end
                    SW_PROGRAM:
                    begin
                        f_raddr = sw_addr;
                        f_we    = (cnt_reg != '0);
                        f_waddr = sw_addr - ADDR_BITS'(1);
                        f_wdata = f_rdata & p_rdata;
                        limit   = LIM_PROG;
                    end
                    SW_PBFILL:
                    begin
                        p_we    = 1'b1;
                        p_waddr = cnt_reg[7:0];
                        p_wdata = 8'hFF;
                        limit   = LIM_PB;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_PROGRAM] <= 32'd1200;
            cfg_reg[CFG_SECTOR]  <= 32'd1500000;
            cfg_reg[CFG_WRSR]    <= 32'd5000;
            cfg_reg[CFG_BULK]    <= 32'd3200000000;
            cfg_reg[CFG_PDOWN]   <= 32'd1000000000;
            cfg_reg[CFG_RELEASE] <= 32'd3000000000;
        end
        else if (cfg_we && (cfg_index <= CFG_RELEASE))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            csn_reg <= s_axis_tdata[0];
            sck_reg <= s_axis_tdata[1];
            din_reg <= s_axis_tdata[5:2];
        end
        if (load)
        begin
            out_data_reg <= dout;
            sw_base_reg  <= sweep.base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= F_CLEAR;
            cnt_reg       <= '0;
            sw_kind_reg   <= SW_NONE;
            out_valid_reg <= 1'b0;
            st_reg        <= '{status: STATUS_RST, setup: SETUP_RST, cmd: CMD_IDLE,
                               prev_clk: 1'b1, shin: '0, shout: '0, bitcnt: '0,
                               addr: '0, quad: 1'b0, cont: '0, busy: '0};
        end
        else
        begin
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (fsm_reg)
                F_CLEAR:
                begin
                    if (cnt_reg == LIM_ALL)
                    begin
                        cnt_reg <= '0;
                        fsm_reg <= F_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                F_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        fsm_reg <= F_EXEC;
                    end
                end
                F_EXEC:
                begin
                    if (load)
                    begin
                        st_reg        <= nst;
                        out_valid_reg <= 1'b1;
                        cnt_reg       <= '0;
                        sw_kind_reg   <= sweep.kind;
                        fsm_reg       <= (sweep.kind == SW_NONE) ? F_IDLE : F_SWEEP;
                    end
                end
                F_SWEEP:
                begin
                    if (cnt_reg == limit)
                    begin
                        cnt_reg <= '0;
                        fsm_reg <= F_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                default:
                begin
                    fsm_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
